@@ rtl/core/timed_task_slot_scheduler_assert.svh @@
// Assertion macros for the scheduler RTL, used by the back end
`ifndef TIMED_TASK_SLOT_SCHEDULER_ASSERT_SVH
`define TIMED_TASK_SLOT_SCHEDULER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define TTS_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TTS_ASSERT_NXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ rtl/core/tts_pkg.sv @@
// Shared types, constants and helpers for the timed task slot scheduler
`timescale 1ns / 1ps

package tts_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

   localparam int TIME_W = 32;
   localparam int TAG_W  = 16;
   localparam logic [TIME_W-1:0] IDLE_WINDOW_RESET = 32'd10;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_KILL = 2'd1,
      OP_TICK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_FREE   = 2'd0,
      KIND_ONCE   = 2'd1,
      KIND_CYCLIC = 2'd2,
      KIND_IDLE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      EV_ADDED    = 3'd0,
      EV_REFUSED  = 3'd1,
      EV_KILLED   = 3'd2,
      EV_FIRE     = 3'd3,
      EV_IDLE     = 3'd4,
      EV_TICK_END = 3'd5
   } event_type;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REFUSE = 2'd1,
      CMD_KILL   = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_code_type;

   // classified command handed from front to back
   typedef struct packed {
      cmd_code_type      code;
      kind_type          kind;
      logic [TIME_W-1:0] act;      // activation time for add, current time for tick
      logic [TIME_W-1:0] per;
      logic [TAG_W-1:0]  tag;
      logic              kill_hit;
      logic [SLOT_W-1:0] kill_idx;
   } cmd_type;

   function automatic logic [2:0] slot_code(input logic [SLOT_W-1:0] idx);
      logic [7:0] wide;
      begin
         wide = 8'(idx);
         return wide[2:0];
      end
   endfunction

endpackage

@@ rtl/core/tts_front.sv @@
// Front end: accepts requests, classifies them and queues commands for the back end
`timescale 1ns / 1ps

module tts_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [tts_pkg::TIME_W-1:0]   req_now,
   input  logic [1:0]                   req_task_kind,
   input  logic [tts_pkg::TIME_W-1:0]   req_time_value,
   input  logic [tts_pkg::TAG_W-1:0]    req_task_tag,
   input  logic [7:0]                   req_kill_slot,
   output logic                         q_valid,
   output tts_pkg::cmd_type             q_cmd,
   input  logic                         q_pop
);

   tts_pkg::cmd_type                  cmd;
   logic                              cmd_keep;
   logic                              push;
   tts_pkg::kind_type                 kind;

   tts_pkg::cmd_type                  queue_ff [tts_pkg::QUEUE_DEPTH];
   logic [tts_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [tts_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [tts_pkg::QUEUE_CW-1:0]      count_ff, count_in;

   assign kind = tts_pkg::kind_type'(req_task_kind);

   always_comb begin
      cmd          = '0;
      cmd_keep     = 1'b1;
      cmd.kind     = kind;
      cmd.tag      = req_task_tag;
      cmd.kill_hit = (req_kill_slot < 8'(tts_pkg::SLOT_COUNT));
      cmd.kill_idx = req_kill_slot[tts_pkg::SLOT_W-1:0];
      unique case (req_op)
         tts_pkg::OP_ADD: begin
            if (kind == tts_pkg::KIND_FREE) begin
               cmd.code = tts_pkg::CMD_REFUSE;
            end else begin
               cmd.code = tts_pkg::CMD_ADD;
            end
            // once: due at now plus the delay; cyclic: due at first tick
            cmd.act  = (kind == tts_pkg::KIND_ONCE) ? (req_now + req_time_value) : '0;
            cmd.per  = (kind == tts_pkg::KIND_CYCLIC) ? req_time_value : '0;
         end
         tts_pkg::OP_KILL: begin
            cmd.code = tts_pkg::CMD_KILL;
         end
         tts_pkg::OP_TICK: begin
            cmd.code = tts_pkg::CMD_TICK;
            cmd.act  = req_now;
         end
         default: begin
            cmd.code = tts_pkg::CMD_KILL;
            cmd_keep = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == tts_pkg::QUEUE_CW'(tts_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && cmd_keep;
   assign q_valid   = (count_ff != '0);
   assign q_cmd     = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == tts_pkg::QUEUE_AW'(tts_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + tts_pkg::QUEUE_AW'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == tts_pkg::QUEUE_AW'(tts_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + tts_pkg::QUEUE_AW'(1);
      end
      priority if (push && !q_pop) begin
         count_in = count_ff + tts_pkg::QUEUE_CW'(1);
      end else if (!push && q_pop) begin
         count_in = count_ff - tts_pkg::QUEUE_CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

@@ rtl/core/tts_back.sv @@
// Back end: slot table, tick walker and result register
`timescale 1ns / 1ps

`include "timed_task_slot_scheduler_assert.svh"

module tts_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   input  tts_pkg::cmd_type             q_cmd,
   output logic                         q_pop,
   input  logic                         csr_wr_en,
   input  logic [tts_pkg::TIME_W-1:0]   csr_wr_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_event_res,
   output logic [2:0]                   rsp_slot,
   output logic [tts_pkg::TAG_W-1:0]    rsp_tag,
   output logic                         rsp_was_idle,
   output logic                         rsp_last
);

   typedef enum logic [3:0] {
      ST_WAIT  = 4'b0001,
      ST_TIMED = 4'b0010,
      ST_IDLES = 4'b0100,
      ST_END   = 4'b1000
   } state_type;

   state_type                      state_ff, state_in;
   logic [tts_pkg::SLOT_W-1:0]     slot_idx_ff, slot_idx_in;
   logic [tts_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [tts_pkg::TIME_W-1:0]     horizon_ff, horizon_in;
   logic                           idle_ff, idle_in;
   logic [tts_pkg::TIME_W-1:0]     idle_window_ff;

   tts_pkg::kind_type              slot_kind_ff [tts_pkg::SLOT_COUNT];
   logic [tts_pkg::TIME_W-1:0]     act_ff       [tts_pkg::SLOT_COUNT];
   logic [tts_pkg::TIME_W-1:0]     per_ff       [tts_pkg::SLOT_COUNT];
   logic [tts_pkg::TAG_W-1:0]      tag_ff       [tts_pkg::SLOT_COUNT];

   logic                           tbl_we;
   logic [tts_pkg::SLOT_W-1:0]     tbl_idx;
   tts_pkg::kind_type              tbl_kind;
   logic [tts_pkg::TIME_W-1:0]     tbl_act;
   logic [tts_pkg::TIME_W-1:0]     tbl_per;
   logic [tts_pkg::TAG_W-1:0]      tbl_tag;

   tts_pkg::kind_type              cur_kind;
   logic [tts_pkg::TIME_W-1:0]     cur_act;
   logic [tts_pkg::TIME_W-1:0]     cur_per;
   logic [tts_pkg::TAG_W-1:0]      cur_tag;
   logic                           is_timed;
   logic                           due;
   logic [tts_pkg::TIME_W-1:0]     new_act;
   logic                           stop_idle;
   logic                           want_emit;
   logic                           step;

   logic                           free_hit;
   logic [tts_pkg::SLOT_W-1:0]     free_idx;

   logic                           out_free;
   logic                           emit;
   logic                           rsp_valid_ff, rsp_valid_in;
   tts_pkg::event_type             rsp_event_ff, rsp_event_in;
   logic [2:0]                     rsp_slot_ff, rsp_slot_in;
   logic [tts_pkg::TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic                           rsp_idle_ff, rsp_idle_in;
   logic                           rsp_last_ff, rsp_last_in;

   assign cur_kind = slot_kind_ff[slot_idx_ff];
   assign cur_act  = act_ff[slot_idx_ff];
   assign cur_per  = per_ff[slot_idx_ff];
   assign cur_tag  = tag_ff[slot_idx_ff];

   assign is_timed  = (cur_kind == tts_pkg::KIND_ONCE) || (cur_kind == tts_pkg::KIND_CYCLIC);
   assign due       = (cur_act <= now_ff);
   // a fired once slot is wiped, so its time reads as zero
   assign new_act   = !due ? cur_act :
                      (cur_kind == tts_pkg::KIND_ONCE) ? '0 : (now_ff + cur_per);
   assign stop_idle = is_timed && (new_act <= horizon_ff);

   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // lowest free slot
   always_comb begin
      free_hit = 1'b0;
      free_idx = '0;
      for (int i = tts_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (slot_kind_ff[i] == tts_pkg::KIND_FREE) begin
            free_hit = 1'b1;
            free_idx = tts_pkg::SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      slot_idx_in  = slot_idx_ff;
      now_in       = now_ff;
      horizon_in   = horizon_ff;
      idle_in      = idle_ff;
      q_pop        = 1'b0;
      emit         = 1'b0;
      want_emit    = 1'b0;
      step         = 1'b0;
      rsp_event_in = rsp_event_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_idle_in  = rsp_idle_ff;
      rsp_last_in  = rsp_last_ff;
      tbl_we       = 1'b0;
      tbl_idx      = slot_idx_ff;
      tbl_kind     = cur_kind;
      tbl_act      = cur_act;
      tbl_per      = cur_per;
      tbl_tag      = cur_tag;

      unique case (state_ff)
         ST_WAIT: begin
            if (q_valid) begin
               unique case (q_cmd.code)
                  tts_pkg::CMD_ADD, tts_pkg::CMD_REFUSE: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        emit         = 1'b1;
                        rsp_idle_in  = 1'b0;
                        rsp_last_in  = 1'b1;
                        if (q_cmd.code == tts_pkg::CMD_ADD && free_hit) begin
                           tbl_we       = 1'b1;
                           tbl_idx      = free_idx;
                           tbl_kind     = q_cmd.kind;
                           tbl_act      = q_cmd.act;
                           tbl_per      = q_cmd.per;
                           tbl_tag      = q_cmd.tag;
                           rsp_event_in = tts_pkg::EV_ADDED;
                           rsp_slot_in  = tts_pkg::slot_code(free_idx);
                           rsp_tag_in   = q_cmd.tag;
                        end else begin
                           rsp_event_in = tts_pkg::EV_REFUSED;
                           rsp_slot_in  = '0;
                           rsp_tag_in   = '0;
                        end
                     end
                  end
                  tts_pkg::CMD_KILL: begin
                     if (out_free) begin
                        q_pop        = 1'b1;
                        emit         = 1'b1;
                        rsp_event_in = tts_pkg::EV_KILLED;
                        rsp_slot_in  = '0;
                        rsp_tag_in   = '0;
                        rsp_idle_in  = 1'b0;
                        rsp_last_in  = 1'b1;
                        tbl_we       = q_cmd.kill_hit;
                        tbl_idx      = q_cmd.kill_idx;
                        tbl_kind     = tts_pkg::KIND_FREE;
                        tbl_act      = '0;
                        tbl_per      = '0;
                        tbl_tag      = '0;
                     end
                  end
                  tts_pkg::CMD_TICK: begin
                     q_pop       = 1'b1;
                     now_in      = q_cmd.act;
                     horizon_in  = q_cmd.act + idle_window_ff;
                     idle_in     = 1'b1;
                     slot_idx_in = '0;
                     state_in    = ST_TIMED;
                  end
                  default: begin
                     q_pop = 1'b0;
                  end
               endcase
            end
         end

         ST_TIMED: begin
            want_emit = is_timed && due && (cur_tag != '0);
            step      = !want_emit || out_free;
            if (step) begin
               if (is_timed && due) begin
                  tbl_we  = 1'b1;
                  tbl_act = new_act;
                  if (cur_kind == tts_pkg::KIND_ONCE) begin
                     tbl_kind = tts_pkg::KIND_FREE;
                     tbl_per  = '0;
                     tbl_tag  = '0;
                  end
               end
               if (want_emit) begin
                  emit         = 1'b1;
                  rsp_event_in = tts_pkg::EV_FIRE;
                  rsp_slot_in  = tts_pkg::slot_code(slot_idx_ff);
                  rsp_tag_in   = cur_tag;
                  rsp_idle_in  = 1'b0;
                  rsp_last_in  = 1'b0;
               end
               if (stop_idle) begin
                  idle_in = 1'b0;
               end
               if (slot_idx_ff == tts_pkg::LAST_SLOT) begin
                  slot_idx_in = '0;
                  if (idle_ff && !stop_idle) begin
                     state_in = ST_IDLES;
                  end else begin
                     state_in = ST_END;
                  end
               end else begin
                  slot_idx_in = slot_idx_ff + tts_pkg::SLOT_W'(1);
               end
            end
         end

         ST_IDLES: begin
            want_emit = (cur_kind == tts_pkg::KIND_IDLE) && (cur_tag != '0);
            step      = !want_emit || out_free;
            if (step) begin
               if (want_emit) begin
                  emit         = 1'b1;
                  rsp_event_in = tts_pkg::EV_IDLE;
                  rsp_slot_in  = tts_pkg::slot_code(slot_idx_ff);
                  rsp_tag_in   = cur_tag;
                  rsp_idle_in  = 1'b0;
                  rsp_last_in  = 1'b0;
               end
               if (slot_idx_ff == tts_pkg::LAST_SLOT) begin
                  slot_idx_in = '0;
                  state_in    = ST_END;
               end else begin
                  slot_idx_in = slot_idx_ff + tts_pkg::SLOT_W'(1);
               end
            end
         end

         ST_END: begin
            if (out_free) begin
               emit         = 1'b1;
               rsp_event_in = tts_pkg::EV_TICK_END;
               rsp_slot_in  = '0;
               rsp_tag_in   = '0;
               rsp_idle_in  = idle_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_WAIT;
            end
         end

         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   always_comb begin
      priority if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_WAIT;
         slot_idx_ff    <= '0;
         idle_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         idle_window_ff <= tts_pkg::IDLE_WINDOW_RESET;
         for (int i = 0; i < tts_pkg::SLOT_COUNT; i++) begin
            slot_kind_ff[i] <= tts_pkg::KIND_FREE;
         end
      end else begin
         state_ff     <= state_in;
         slot_idx_ff  <= slot_idx_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            idle_window_ff <= csr_wr_data;
         end
         if (tbl_we) begin
            slot_kind_ff[tbl_idx] <= tbl_kind;
         end
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      horizon_ff   <= horizon_in;
      rsp_event_ff <= rsp_event_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_idle_ff  <= rsp_idle_in;
      rsp_last_ff  <= rsp_last_in;
      if (tbl_we) begin
         act_ff[tbl_idx] <= tbl_act;
         per_ff[tbl_idx] <= tbl_per;
         tag_ff[tbl_idx] <= tbl_tag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_tag       = rsp_tag_ff;
   assign rsp_was_idle  = rsp_idle_ff;
   assign rsp_last      = rsp_last_ff;

   `TTS_ASSERT_IMP(a_mid_results_are_runs,
                   rsp_valid_ff && !rsp_last_ff,
                   rsp_event_ff == tts_pkg::EV_FIRE || rsp_event_ff == tts_pkg::EV_IDLE,
                   "non-final result is not a fire or idle run")
   `TTS_ASSERT_NXT(a_end_emits_last,
                   state_ff == ST_END && out_free,
                   rsp_valid_ff && rsp_last_ff && rsp_event_ff == tts_pkg::EV_TICK_END,
                   "tick end not issued")
   `TTS_ASSERT_IMP(a_pop_needs_cmd, q_pop, q_valid, "pop from empty command queue")
   `TTS_ASSERT_IMP(a_idle_pass_flag, state_ff == ST_IDLES, idle_ff,
                   "idle pass entered with idle flag clear")

endmodule

@@ rtl/core/timed_task_slot_scheduler.sv @@
// Top level of the timed task slot scheduler
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall | op, now, task_kind, time_value, task_tag, kill_slot
//  rsp     | out | rsp_valid/rsp_stall | event_res, slot, tag, was_idle, last
//  csr     | in  | csr_wr_en           | csr_wr_data (idle window)
//
// Requests go into a 2-deep command queue; req_stall is high only while it is full.
// Add, refused add and kill are each handled straight from the wait state. Tick: a setup
// step in the wait state, a timed walk over every slot, an idle walk over every slot when
// taken, then tick end; the single-slot walker visits one slot at a time.
// Synchronous reset frees every slot at once; no clearing pass is needed.
// A stalled result holds the walker on the slot that wants to emit.
`timescale 1ns / 1ps

module timed_task_slot_scheduler (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [tts_pkg::TIME_W-1:0]   req_now,
   input  logic [1:0]                   req_task_kind,
   input  logic [tts_pkg::TIME_W-1:0]   req_time_value,
   input  logic [tts_pkg::TAG_W-1:0]    req_task_tag,
   input  logic [7:0]                   req_kill_slot,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_event_res,
   output logic [2:0]                   rsp_slot,
   output logic [tts_pkg::TAG_W-1:0]    rsp_tag,
   output logic                         rsp_was_idle,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic [tts_pkg::TIME_W-1:0]   csr_wr_data
);

   logic             q_valid;
   logic             q_pop;
   tts_pkg::cmd_type q_cmd;

   tts_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_now        (req_now),
      .req_task_kind  (req_task_kind),
      .req_time_value (req_time_value),
      .req_task_tag   (req_task_tag),
      .req_kill_slot  (req_kill_slot),
      .q_valid        (q_valid),
      .q_cmd          (q_cmd),
      .q_pop          (q_pop)
   );

   tts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .rsp_slot      (rsp_slot),
      .rsp_tag       (rsp_tag),
      .rsp_was_idle  (rsp_was_idle),
      .rsp_last      (rsp_last)
   );

endmodule
